[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");
`endif

[rtl/srctok_pkg.sv]
// Source tokenizer package: token kinds, scanner modes, error codes, keyword table.
// Depends on nothing.
package srctok_pkg;
  localparam int KindW = 6;
  localparam int ErrW  = 3;

  localparam logic [KindW-1:0] K_END = 6'd0, K_NEWLINE = 6'd1, K_NUMBER = 6'd2,
    K_FLOAT = 6'd3, K_IDENT = 6'd4, K_STRING = 6'd5, K_CHAR = 6'd6, K_TYPE = 6'd7,
    K_KW0 = 6'd8, K_PLUS = 6'd30, K_MINUS = 6'd31, K_STAR = 6'd32, K_SLASH = 6'd33,
    K_EQ = 6'd34, K_EQEQ = 6'd35, K_GT = 6'd36, K_GTEQ = 6'd37, K_RSHIFT = 6'd38,
    K_LT = 6'd39, K_LTEQ = 6'd40, K_LSHIFT = 6'd41, K_BANGEQ = 6'd42, K_BOR = 6'd43,
    K_LOR = 6'd44, K_BAND = 6'd45, K_LAND = 6'd46, K_HASH = 6'd47, K_LPAREN = 6'd48,
    K_RPAREN = 6'd49, K_LBRACE = 6'd50, K_RBRACE = 6'd51, K_SEMI = 6'd52,
    K_COMMA = 6'd53, K_DOT = 6'd54, K_LSQUARE = 6'd55, K_RSQUARE = 6'd56,
    K_COLON = 6'd57, K_ERROR = 6'd58;

  localparam logic [ErrW-1:0] E_NONE = 3'd0, E_BANG = 3'd1, E_STRCTL = 3'd2,
    E_CHARHI = 3'd3, E_CHARCTL = 3'd4, E_CHARLEN = 3'd5, E_UNEXP = 3'd6,
    E_UNTERM = 3'd7;

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_SLASH, M_LINECMT, M_BLOCK, M_BLOCKSTAR, M_STRING,
    M_CHARLIT, M_DEC, M_FLOAT, M_HEX, M_TYPE, M_WORD
  } mode_t;

  localparam int NumKw = 22;
  typedef logic [63:0] kw_word_t;

  // Keyword text, first character in the low byte, zero padded.
  function automatic kw_word_t kw_text(input int i);
    unique case (i)
      0: kw_text = 64'h6C_6562_616C;
      1: kw_text = 64'h6F_746F67;
      2: kw_text = 64'h74_656C;
      3: kw_text = 64'h6669;
      4: kw_text = 64'h65_736C65;
      5: kw_text = 64'h66_696C65;
      6: kw_text = 64'h65_6C6968_77;
      7: kw_text = 64'h65_6475_6C63_6E69;
      8: kw_text = 64'h6E_7275_7465_72;
      9: kw_text = 64'h63_6E75_66;
      10: kw_text = 64'h6E_7265_7478_65;
      11: kw_text = 64'h74_6375_7274_73;
      12: kw_text = 64'h66_6564_6570_7974;
      13: kw_text = 64'h72_6F66;
      14: kw_text = 64'h6B_6165_7262;
      15: kw_text = 64'h6575_6E69_746E_6F63;
      16: kw_text = 64'h68_6374_6977_73;
      17: kw_text = 64'h65_7361_63;
      18: kw_text = 64'h6D_756E_65;
      19: kw_text = 64'h72_6564_6165_68;
      20: kw_text = 64'h63_7478_65;
      default: kw_text = 64'h6D_6F72_66;
    endcase
  endfunction

  function automatic int kw_len(input int i);
    unique case (i)
      3: kw_len = 2;
      2, 13: kw_len = 3;
      1, 4, 5, 9, 17, 18, 20, 21: kw_len = 4;
      0, 6, 14: kw_len = 5;
      8, 10, 11, 16, 19: kw_len = 6;
      7, 12: kw_len = 7;
      default: kw_len = 8;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic logic is_ctl(input logic [7:0] b);
    return b == 8'h0D || b == 8'h0A || b == 8'h09;
  endfunction
endpackage

[rtl/srctok_kwmatch.sv]
// Keyword matcher: maps a buffered word to a keyword kind or identifier.
// Depends on srctok_pkg.
module srctok_kwmatch #(
  parameter int LenW = 24,
  parameter int KwMax = 8
) (
  input  logic [63:0]                word,
  input  logic [LenW-1:0]            len,
  input  logic                       too_long,
  output logic [srctok_pkg::KindW-1:0] kind
);
  import srctok_pkg::*;

  // Compare against every keyword in parallel; at most one can match.
  always_comb begin
    kind = K_IDENT;
    if (!too_long && len <= LenW'(KwMax) && len <= LenW'(8)) begin
      for (int i = 0; i < NumKw; i++) begin
        if (len == LenW'(kw_len(i)) && word == kw_text(i)) kind = K_KW0 + KindW'(i);
      end
    end
  end
endmodule

[rtl/source_tokenizer.sv]
// Top level of the source tokenizer: scanner state and result queue.
// Depends on srctok_pkg and srctok_kwmatch.
//
// Usage: the input channel (in_valid / in_stall) carries one beat per
// source byte (action 0) or an end-of-source beat (action 1). The output
// channel (out_valid / out_stall) carries token beats, each with kind,
// start, length, line, numeric value, error code and a last flag marking
// the final beat caused by one input beat (up to three beats per input).
// Each input beat is scanned combinationally, and its results are
// registered into a four-entry result queue. Throughput is one input
// beat per cycle while each beat yields at most one result and the
// receiver does not stall; beats yielding two or three results drain
// one at a time through the single output port. The input is stalled
// when the queue cannot hold three more results. When the receiver stalls,
// the head beat holds and the queue fills, then the input is stalled.
// Synchronous reset returns the scanner to idle between tokens at offset
// zero, line one, and empties the queue. After an error or the end token
// the block halts and yields no results until reset.
module source_tokenizer #(
  parameter int OFFSET_BITS = 24,
  parameter int KEYWORD_MAX_LEN = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [7:0]           source_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [srctok_pkg::KindW-1:0] token_kind,
  output logic [OFFSET_BITS-1:0] token_start,
  output logic [OFFSET_BITS-1:0] token_length,
  output logic [OFFSET_BITS-1:0] token_line,
  output logic [31:0]          number_value,
  output logic [srctok_pkg::ErrW-1:0] error_code,
  output logic                 last
);
  import srctok_pkg::*;

  localparam int OW = OFFSET_BITS;
  localparam int VW = VALUE_BITS;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [OW-1:0]    start;
    logic [OW-1:0]    len;
    logic [OW-1:0]    line;
    logic [31:0]      val;
    logic [ErrW-1:0]  err;
    logic             fin;
  } res_t;

  // Scanner state.
  mode_t         mode, mode_next;
  logic [7:0]    pend, pend_next;
  logic [OW-1:0] pos, pos_next, lcount, lcount_next, soff, soff_next, sline, sline_next;
  logic [63:0]   wbuf, wbuf_next;
  logic          wlong, wlong_next, esc_p, esc_p_next, esc_s, esc_s_next;
  logic [VW-1:0] acc, acc_next;
  logic          halted, halted_next;

  // Result queue.
  res_t        q [4];
  logic [1:0]  rd_ptr, wr_ptr;
  logic [2:0]  count;
  res_t        r [3];
  logic [1:0]  nres;

  logic take_in, take_out;
  assign in_stall = (count > 3'd1);
  assign take_in  = in_valid && !in_stall;
  assign take_out = out_valid && !out_stall;
  assign out_valid = (count != 3'd0);

  logic [KindW-1:0] wkind;
  logic [OW-1:0] span;
  assign span = pos - soff;

  srctok_kwmatch #(.LenW(OW), .KwMax(KEYWORD_MAX_LEN)) u_kw (
    .word(wbuf), .len(span), .too_long(wlong), .kind(wkind)
  );

  logic [7:0] b;
  logic [3:0] hv;
  logic       hok;
  always_comb begin
    b = action ? 8'h0A : source_byte;
    hok = 1'b1;
    if (is_digit(b)) hv = 4'(b - "0");
    else if (b >= "a" && b <= "f") hv = 4'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") hv = 4'(b - "A" + 8'd10);
    else begin
      hv = 4'd0;
      hok = 1'b0;
    end
  end

  // Combinational scanner: mirrors the byte rules, emitting up to three results.
  always_comb begin
    logic             do_idle, do_close, op_two;
    logic [KindW-1:0] ck, one, two, ik;
    logic [VW-1:0]    cval;
    logic             ihit;
    mode_next = mode; pend_next = pend; soff_next = soff; sline_next = sline;
    wbuf_next = wbuf; wlong_next = wlong; esc_p_next = esc_p; esc_s_next = esc_s;
    acc_next = acc; halted_next = halted;
    pos_next = pos + OW'(1);
    lcount_next = (b == 8'h0A) ? lcount + OW'(1) : lcount;
    nres = 2'd0;
    for (int i = 0; i < 3; i++) r[i] = '0;
    do_idle = 1'b0; do_close = 1'b0; ck = K_END; cval = '0;
    one = K_EQ; two = K_END; op_two = 1'b0; ik = K_END; ihit = 1'b0;

    unique case (mode)
      M_OP: begin
        unique case (pend)
          "=": begin one = K_EQ; if (b == "=") begin two = K_EQEQ; op_two = 1'b1; end end
          ">": begin
            one = K_GT;
            if (b == "=") begin two = K_GTEQ; op_two = 1'b1; end
            else if (b == ">") begin two = K_RSHIFT; op_two = 1'b1; end
          end
          "<": begin
            one = K_LT;
            if (b == "=") begin two = K_LTEQ; op_two = 1'b1; end
            else if (b == "<") begin two = K_LSHIFT; op_two = 1'b1; end
          end
          "!": begin one = K_EQ; if (b == "=") begin two = K_BANGEQ; op_two = 1'b1; end end
          "|": begin one = K_BOR; if (b == "|") begin two = K_LOR; op_two = 1'b1; end end
          "&": begin one = K_BAND; if (b == "&") begin two = K_LAND; op_two = 1'b1; end end
          default: one = K_EQ;
        endcase
        if (op_two) begin
          r[0] = '{two, soff, OW'(2), sline, 32'd0, E_NONE, 1'b0};
          nres = 2'd1;
          mode_next = M_IDLE;
        end else if (pend == "!") begin
          r[0] = '{K_ERROR, pos, '0, lcount, 32'd0, E_BANG, 1'b0};
          nres = 2'd1;
          mode_next = M_IDLE;
          halted_next = 1'b1;
        end else begin
          do_close = 1'b1; ck = one; do_idle = 1'b1;
        end
      end
      M_SLASH: begin
        if (b == "/") mode_next = M_LINECMT;
        else if (b == "*") mode_next = M_BLOCK;
        else begin do_close = 1'b1; ck = K_SLASH; do_idle = 1'b1; end
      end
      M_LINECMT: if (b == 8'h0A) do_idle = 1'b1;
      M_BLOCK: if (b == "*") mode_next = M_BLOCKSTAR;
      M_BLOCKSTAR: begin
        if (b == "/") mode_next = M_IDLE;
        else if (b != "*") mode_next = M_BLOCK;
      end
      M_STRING: begin
        if (!esc_p && b == "\"") begin
          do_close = 1'b1; ck = K_STRING;
        end else begin
          esc_p_next = 1'b0;
          if (is_ctl(b)) begin
            r[0] = '{K_ERROR, pos, '0, lcount, 32'd0, E_STRCTL, 1'b0};
            nres = 2'd1; halted_next = 1'b1;
          end else if (b == "\\") esc_p_next = 1'b1;
        end
      end
      M_CHARLIT: begin
        if (!esc_p && b == "'") begin
          if (span > (esc_s ? OW'(2) : OW'(1))) begin
            r[0] = '{K_ERROR, pos, '0, lcount, 32'd0, E_CHARLEN, 1'b0};
            nres = 2'd1; halted_next = 1'b1;
          end else begin
            do_close = 1'b1; ck = K_CHAR;
          end
        end else begin
          esc_p_next = 1'b0;
          if (b > 8'd127) begin
            r[0] = '{K_ERROR, pos, '0, lcount, 32'd0, E_CHARHI, 1'b0};
            nres = 2'd1; halted_next = 1'b1;
          end else if (is_ctl(b)) begin
            r[0] = '{K_ERROR, pos, '0, lcount, 32'd0, E_CHARCTL, 1'b0};
            nres = 2'd1; halted_next = 1'b1;
          end else if (b == "\\") begin
            esc_p_next = 1'b1; esc_s_next = 1'b1;
          end
        end
      end
      M_DEC: begin
        if (span == OW'(1) && b == "x") begin
          mode_next = M_HEX; acc_next = '0;
        end else if (is_digit(b)) begin
          acc_next = VW'((acc << 3) + (acc << 1) + VW'(b - "0"));
        end else if (b == ".") mode_next = M_FLOAT;
        else begin do_close = 1'b1; ck = K_NUMBER; cval = acc; do_idle = 1'b1; end
      end
      M_FLOAT: if (!is_digit(b)) begin do_close = 1'b1; ck = K_FLOAT; do_idle = 1'b1; end
      M_HEX: begin
        if (hok) acc_next = (acc << 4) | VW'(hv);
        else begin do_close = 1'b1; ck = K_NUMBER; cval = acc; do_idle = 1'b1; end
      end
      M_TYPE: if (!(is_alpha(b) || b == "_")) begin
        do_close = 1'b1; ck = K_TYPE; do_idle = 1'b1;
      end
      M_WORD: begin
        if (is_alpha(b) || is_digit(b) || b == "_") begin
          if (span < OW'(8)) wbuf_next = wbuf | (64'(b) << {span[2:0], 3'b000});
          if (span >= OW'(KEYWORD_MAX_LEN)) wlong_next = 1'b1;
        end else begin
          do_close = 1'b1; ck = wkind; do_idle = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    if (do_close) begin
      r[0] = '{ck, soff, span, sline, 32'(cval), E_NONE, 1'b0};
      nres = 2'd1;
      mode_next = M_IDLE;
    end

    // Byte seen between tokens.
    if (do_idle) begin
      mode_next = M_IDLE;
      priority case (b)
        " ", 8'h09, 8'h0D: ihit = 1'b0;
        "+": begin ik = K_PLUS; ihit = 1'b1; end
        "-": begin ik = K_MINUS; ihit = 1'b1; end
        "*": begin ik = K_STAR; ihit = 1'b1; end
        "#": begin ik = K_HASH; ihit = 1'b1; end
        "(": begin ik = K_LPAREN; ihit = 1'b1; end
        ")": begin ik = K_RPAREN; ihit = 1'b1; end
        "{": begin ik = K_LBRACE; ihit = 1'b1; end
        "}": begin ik = K_RBRACE; ihit = 1'b1; end
        ";": begin ik = K_SEMI; ihit = 1'b1; end
        ",": begin ik = K_COMMA; ihit = 1'b1; end
        ".": begin ik = K_DOT; ihit = 1'b1; end
        "[": begin ik = K_LSQUARE; ihit = 1'b1; end
        "]": begin ik = K_RSQUARE; ihit = 1'b1; end
        ":": begin ik = K_COLON; ihit = 1'b1; end
        8'h0A: begin ik = K_NEWLINE; ihit = 1'b1; end
        8'h00: begin ik = K_END; ihit = 1'b1; end
        "=", ">", "<", "!", "|", "&": begin
          pend_next = b; mode_next = M_OP; soff_next = pos; sline_next = lcount;
        end
        "/": begin mode_next = M_SLASH; soff_next = pos; sline_next = lcount; end
        "\"", "'": begin
          mode_next = (b == "\"") ? M_STRING : M_CHARLIT;
          soff_next = pos + OW'(1); sline_next = lcount;
          esc_p_next = 1'b0; esc_s_next = 1'b0;
        end
        "@": begin mode_next = M_TYPE; soff_next = pos + OW'(1); sline_next = lcount; end
        default: begin
          if (is_digit(b)) begin
            mode_next = M_DEC; soff_next = pos; sline_next = lcount;
            acc_next = VW'(b - "0");
          end else if (is_alpha(b)) begin
            mode_next = M_WORD; soff_next = pos; sline_next = lcount;
            wbuf_next = 64'(b); wlong_next = 1'b0;
          end else begin
            r[nres] = '{K_ERROR, pos, '0, lcount, 32'd0, E_UNEXP, 1'b0};
            nres = nres + 2'd1; halted_next = 1'b1;
          end
        end
      endcase
      if (ihit) begin
        r[nres] = '{ik, pos, OW'(1), lcount, 32'd0, E_NONE, 1'b0};
        nres = nres + 2'd1;
      end
    end

    // End of source: closing token, or an unterminated-comment error, after the implied newline.
    if (action && !halted_next) begin
      if (mode_next == M_BLOCK || mode_next == M_BLOCKSTAR)
        r[nres] = '{K_ERROR, pos_next, '0, lcount_next, 32'd0, E_UNTERM, 1'b0};
      else
        r[nres] = '{K_END, pos_next, '0, lcount_next, 32'd0, E_NONE, 1'b0};
      nres = nres + 2'd1;
      mode_next = M_IDLE;
      halted_next = 1'b1;
    end
    if (nres != 2'd0) r[nres - 2'd1].fin = 1'b1;
  end

  // State and queue registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pend <= '0; pos <= '0; lcount <= OW'(1); soff <= '0;
      sline <= OW'(1); wbuf <= '0; wlong <= 1'b0; acc <= '0; esc_p <= 1'b0;
      esc_s <= 1'b0; halted <= 1'b0; rd_ptr <= '0; wr_ptr <= '0; count <= '0;
    end else begin
      if (take_in && !halted) begin
        mode <= mode_next; pend <= pend_next; pos <= pos_next; lcount <= lcount_next;
        soff <= soff_next; sline <= sline_next; wbuf <= wbuf_next; wlong <= wlong_next;
        acc <= acc_next; esc_p <= esc_p_next; esc_s <= esc_s_next;
        halted <= halted_next;
        for (int i = 0; i < 3; i++)
          if (2'(i) < nres) q[wr_ptr + 2'(i)] <= r[i];
        wr_ptr <= wr_ptr + nres;
      end
      if (take_out) rd_ptr <= rd_ptr + 2'd1;
      count <= count + ((take_in && !halted) ? {1'b0, nres} : 3'd0)
                     - (take_out ? 3'd1 : 3'd0);
    end
  end

  assign token_kind   = q[rd_ptr].kind;
  assign token_start  = q[rd_ptr].start;
  assign token_length = q[rd_ptr].len;
  assign token_line   = q[rd_ptr].line;
  assign number_value = q[rd_ptr].val;
  assign error_code   = q[rd_ptr].err;
  assign last         = q[rd_ptr].fin;
endmodule

[rtl/srctok_checker.sv]
// Port-level checker for the source tokenizer, bound to the top level.
// Depends on srctok_pkg and assert_macros.svh.
`include "assert_macros.svh"
module srctok_checker #(
  parameter int OFFSET_BITS = 24
) (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic [srctok_pkg::KindW-1:0] token_kind,
  input logic [OFFSET_BITS-1:0] token_length,
  input logic [31:0] number_value,
  input logic [srctok_pkg::ErrW-1:0] error_code
);
  import srctok_pkg::*;

  // Error beats carry a nonzero code, zero length and zero value.
  `CHK_IMPLY(a_err_shape, clk, rst, out_valid && token_kind == K_ERROR,
             error_code != E_NONE && token_length == '0 && number_value == '0)
  // Token beats carry no error code.
  `CHK_IMPLY(a_tok_code, clk, rst, out_valid && token_kind != K_ERROR,
             error_code == E_NONE)
  // A stalled result beat stays presented.
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  // Only numbers carry a value.
  `CHK_IMPLY(a_val_num, clk, rst, out_valid && token_kind != K_NUMBER,
             number_value == '0)
endmodule

bind source_tokenizer srctok_checker #(.OFFSET_BITS(OFFSET_BITS)) u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_stall(out_stall), .token_kind(token_kind),
  .token_length(token_length), .number_value(number_value), .error_code(error_code)
);
